/* rtl/core/llg_pkg.sv */
// shared types, constants and helpers for the llg spin update pipeline
package llg_pkg;

    localparam int FRAC_BITS_DEF = 24;
    localparam int WORD_W        = 32;
    localparam int MAG_W         = 31;
    localparam int PROD_W        = 64;
    localparam int QUO_W         = 32;
    localparam int DIV_LAT       = QUO_W + 3;
    localparam int SQRT_LAT      = 32;
    localparam int REG_IDX_W     = 2;

    localparam logic [REG_IDX_W-1:0] REG_GYRO = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_DAMP = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_STEP = 2'd2;

    typedef logic signed [WORD_W-1:0] word_t;
    typedef logic signed [PROD_W-1:0] prod_t;
    typedef logic [MAG_W-1:0]         mag_t;

    typedef enum logic [1:0] {
        GAIN_IDLE,
        GAIN_SQUARE,
        GAIN_LOAD,
        GAIN_DIVIDE
    } gain_state_t;

    typedef struct packed {
        logic busy;
        mag_t gain;
    } gain_stat_t;

    localparam prod_t SMAX = 64'sd2147483647;
    localparam prod_t SMIN = -64'sd2147483648;

    function automatic word_t sat32(input prod_t v);
        word_t r;
        if (v > SMAX)
            r = 32'sh7fffffff;
        else if (v < SMIN)
            r = 32'sh80000000;
        else
            r = word_t'(v[WORD_W-1:0]);
        return r;
    endfunction

    function automatic prod_t mul_s(input word_t a, input word_t b);
        return prod_t'(a) * prod_t'(b);
    endfunction

endpackage

/* rtl/core/llg_spin_euler_update.sv */
// top level: pipelined llg explicit euler spin update with renormalization
//
// channel   direction  handshake              payload
// -------   ---------  ---------------------  -----------------------------------------
// input     in         in_valid / in_stall    spin_x/y/z, moment, field_x/y/z, last_spin
// output    out        out_valid / out_stall  new_x/y/z, out_moment, out_last
// config    in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// one spin enters per cycle while in_stall is low
// pipeline depth is set by the two 35-stage dividers and the 32-stage square root
// after reset, and after any write of gyro_ratio or damping, the gain unit forms
// gamma/(1+alpha^2) serially; in_stall stays high while it is busy
// a stalled output freezes the whole pipeline; nothing is dropped or repeated
// reset clears valid bits, restarts the gain sequencer and sets the registers to defaults; data regs are not reset
module llg_spin_euler_update #(
    parameter int FRAC_BITS = llg_pkg::FRAC_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input spin transfer
    input  logic                          in_valid,
    output logic                          in_stall,
    input  llg_pkg::word_t                spin_x,
    input  llg_pkg::word_t                spin_y,
    input  llg_pkg::word_t                spin_z,
    input  llg_pkg::mag_t                 moment,
    input  llg_pkg::word_t                field_x,
    input  llg_pkg::word_t                field_y,
    input  llg_pkg::word_t                field_z,
    input  logic                          last_spin,
    // result transfer
    output logic                          out_valid,
    input  logic                          out_stall,
    output llg_pkg::word_t                new_x,
    output llg_pkg::word_t                new_y,
    output llg_pkg::word_t                new_z,
    output llg_pkg::mag_t                 out_moment,
    output logic                          out_last,
    // register writes
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [llg_pkg::REG_IDX_W-1:0] cfg_index,
    input  logic [llg_pkg::WORD_W-1:0]    cfg_data
);
    import llg_pkg::*;

    // stage numbering: 1 input, 6 products ready for damping divide,
    // 41 damped term, 47 squared sum, 79 length, 114 renormalized, 115 output
    localparam int TOT = 6 + DIV_LAT + 6 + SQRT_LAT + DIV_LAT + 1;

    localparam longint ONE      = 64'sd1 <<< FRAC_BITS;
    localparam mag_t   GYRO_RST = mag_t'(ONE);
    localparam mag_t   DAMP_RST = mag_t'((ONE + 5) / 10);
    localparam mag_t   STEP_RST = mag_t'((ONE + 50) / 100);

    typedef struct {
        word_t s [3];
        mag_t  ms;
        logic  last;
    } side_t;

    function automatic prod_t fsh(input prod_t p);
        return p >>> FRAC_BITS;
    endfunction

    // configuration registers
    mag_t gyro_reg, damp_reg, step_reg;
    logic cfg_write, gain_start;
    gain_stat_t gstat;

    // pipeline control
    logic [TOT:1] v_reg;
    logic         pipe_en, accept;

    // stage payload
    side_t side1_reg, side2_reg, side3_reg, side4_reg, side5_reg, side6_reg;
    word_t h1_reg   [3];
    prod_t p2_reg   [6];
    word_t mh3_reg  [3];
    word_t mh4_reg  [3];
    prod_t p4_reg   [6];
    word_t mmh5_reg [3];
    word_t mh5_reg  [3];
    prod_t an6_reg  [3];
    prod_t gm6_reg  [3];

    side_t sideA_reg [DIV_LAT];
    prod_t gmA_reg   [DIV_LAT][3];
    word_t damp_w    [3];

    side_t side42_reg, side43_reg, side44_reg, side45_reg, side46_reg, side47_reg;
    prod_t gm42_reg [3];
    prod_t gd42_reg [3];
    word_t ds43_reg [3];
    prod_t pt44_reg [3];
    word_t ns45_reg [3];
    prod_t sq46_reg [3];
    prod_t nm46_reg [3];
    prod_t nm47_reg [3];
    logic [PROD_W-1:0] sum47_reg;

    logic [QUO_W-1:0] len_w;
    side_t sideB_reg [SQRT_LAT];
    prod_t nmB_reg   [SQRT_LAT][3];

    word_t renorm_w  [3];
    side_t sideC_reg [DIV_LAT];
    logic  lenz_reg  [DIV_LAT];

    word_t new_reg [3];
    mag_t  out_ms_reg;
    logic  out_last_reg;

    // the whole pipeline advances unless a finished result is held back
    assign pipe_en  = !v_reg[TOT] || !out_stall;
    assign in_stall = !pipe_en || gstat.busy;
    assign accept   = in_valid && !in_stall;

    assign cfg_ready  = 1'b1;
    assign cfg_write  = cfg_valid && cfg_ready;
    assign gain_start = cfg_write && (cfg_index == REG_GYRO || cfg_index == REG_DAMP);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gyro_reg <= GYRO_RST;
            damp_reg <= DAMP_RST;
            step_reg <= STEP_RST;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_GYRO: gyro_reg <= cfg_data[MAG_W-1:0];
                REG_DAMP: damp_reg <= cfg_data[MAG_W-1:0];
                REG_STEP: step_reg <= cfg_data[MAG_W-1:0];
                default:  ;
            endcase
        end
    end

    // gain g = gamma / (1 + alpha^2), recomputed serially
    llg_gain_calc #(
        .FRAC_BITS (FRAC_BITS)
    ) u_gain (
        .clk   (clk),
        .rst_n (rst_n),
        .start (gain_start),
        .gamma (gyro_reg),
        .alpha (damp_reg),
        .stat  (gstat)
    );

    // valid bits travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else if (pipe_en)
            v_reg <= {v_reg[TOT-1:1], accept};
    end

    // front end: both cross products, the damping numerator and the precession term
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side1_reg.s[0] <= spin_x;
            side1_reg.s[1] <= spin_y;
            side1_reg.s[2] <= spin_z;
            side1_reg.ms   <= moment;
            side1_reg.last <= last_spin;
            h1_reg[0]      <= field_x;
            h1_reg[1]      <= field_y;
            h1_reg[2]      <= field_z;

            // S x H partial products
            side2_reg <= side1_reg;
            p2_reg[0] <= mul_s(side1_reg.s[1], h1_reg[2]);
            p2_reg[1] <= mul_s(side1_reg.s[2], h1_reg[1]);
            p2_reg[2] <= mul_s(side1_reg.s[2], h1_reg[0]);
            p2_reg[3] <= mul_s(side1_reg.s[0], h1_reg[2]);
            p2_reg[4] <= mul_s(side1_reg.s[0], h1_reg[1]);
            p2_reg[5] <= mul_s(side1_reg.s[1], h1_reg[0]);

            side3_reg <= side2_reg;
            for (int c = 0; c < 3; c++)
                mh3_reg[c] <= sat32(fsh(p2_reg[2*c]) - fsh(p2_reg[2*c+1]));

            // S x MH partial products
            side4_reg <= side3_reg;
            mh4_reg   <= mh3_reg;
            p4_reg[0] <= mul_s(side3_reg.s[1], mh3_reg[2]);
            p4_reg[1] <= mul_s(side3_reg.s[2], mh3_reg[1]);
            p4_reg[2] <= mul_s(side3_reg.s[2], mh3_reg[0]);
            p4_reg[3] <= mul_s(side3_reg.s[0], mh3_reg[2]);
            p4_reg[4] <= mul_s(side3_reg.s[0], mh3_reg[1]);
            p4_reg[5] <= mul_s(side3_reg.s[1], mh3_reg[0]);

            side5_reg <= side4_reg;
            mh5_reg   <= mh4_reg;
            for (int c = 0; c < 3; c++)
                mmh5_reg[c] <= sat32(fsh(p4_reg[2*c]) - fsh(p4_reg[2*c+1]));

            // exact alpha*MMH for the divide, and g*MH for the precession term
            side6_reg <= side5_reg;
            for (int c = 0; c < 3; c++)
            begin
                an6_reg[c] <= mul_s(word_t'({1'b0, damp_reg}), mmh5_reg[c]);
                gm6_reg[c] <= mul_s(word_t'({1'b0, gstat.gain}), mh5_reg[c]);
            end
        end
    end

    // alpha*MMH / ms, truncated toward zero
    for (genvar c = 0; c < 3; c++)
    begin : g_damp_div
        llg_div_pipe u_div (
            .clk (clk),
            .en  (pipe_en),
            .num (an6_reg[c]),
            .den ({1'b0, side6_reg.ms}),
            .quo (damp_w[c])
        );
    end

    // side data rides alongside the damping divider
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sideA_reg[0] <= side6_reg;
            gmA_reg[0]   <= gm6_reg;
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sideA_reg[i] <= sideA_reg[i-1];
                gmA_reg[i]   <= gmA_reg[i-1];
            end
        end
    end

    // derivative, euler step, squared length and the renormalization numerator
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            side42_reg <= sideA_reg[DIV_LAT-1];
            gm42_reg   <= gmA_reg[DIV_LAT-1];
            for (int c = 0; c < 3; c++)
                gd42_reg[c] <= mul_s(word_t'({1'b0, gstat.gain}), damp_w[c]);

            side43_reg <= side42_reg;
            for (int c = 0; c < 3; c++)
                ds43_reg[c] <= sat32(-fsh(gm42_reg[c]) - fsh(gd42_reg[c]));

            side44_reg <= side43_reg;
            for (int c = 0; c < 3; c++)
                pt44_reg[c] <= mul_s(word_t'({1'b0, step_reg}), ds43_reg[c]);

            side45_reg <= side44_reg;
            for (int c = 0; c < 3; c++)
                ns45_reg[c] <= sat32(prod_t'(side44_reg.s[c]) + fsh(pt44_reg[c]));

            side46_reg <= side45_reg;
            for (int c = 0; c < 3; c++)
            begin
                sq46_reg[c] <= mul_s(ns45_reg[c], ns45_reg[c]);
                nm46_reg[c] <= mul_s(ns45_reg[c], word_t'({1'b0, side45_reg.ms}));
            end

            // squares are non-negative and their sum stays below 2^64
            side47_reg <= side46_reg;
            nm47_reg   <= nm46_reg;
            sum47_reg  <= PROD_W'(sq46_reg[0]) + PROD_W'(sq46_reg[1])
                        + PROD_W'(sq46_reg[2]);
        end
    end

    llg_sqrt_pipe u_sqrt (
        .clk  (clk),
        .en   (pipe_en),
        .val  (sum47_reg),
        .root (len_w)
    );

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sideB_reg[0] <= side47_reg;
            nmB_reg[0]   <= nm47_reg;
            for (int i = 1; i < SQRT_LAT; i++)
            begin
                sideB_reg[i] <= sideB_reg[i-1];
                nmB_reg[i]   <= nmB_reg[i-1];
            end
        end
    end

    // renormalize: c' * ms / len
    for (genvar c = 0; c < 3; c++)
    begin : g_norm_div
        llg_div_pipe u_div (
            .clk (clk),
            .en  (pipe_en),
            .num (nmB_reg[SQRT_LAT-1][c]),
            .den (len_w),
            .quo (renorm_w[c])
        );
    end

    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            sideC_reg[0] <= sideB_reg[SQRT_LAT-1];
            lenz_reg[0]  <= (len_w == '0);
            for (int i = 1; i < DIV_LAT; i++)
            begin
                sideC_reg[i] <= sideC_reg[i-1];
                lenz_reg[i]  <= lenz_reg[i-1];
            end
        end
    end

    // output register: empty site or collapsed vector keeps the input spin
    always_ff @(posedge clk)
    begin
        if (pipe_en)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (sideC_reg[DIV_LAT-1].ms == '0 || lenz_reg[DIV_LAT-1])
                    new_reg[c] <= sideC_reg[DIV_LAT-1].s[c];
                else
                    new_reg[c] <= renorm_w[c];
            end
            out_ms_reg   <= sideC_reg[DIV_LAT-1].ms;
            out_last_reg <= sideC_reg[DIV_LAT-1].last;
        end
    end

    assign out_valid  = v_reg[TOT];
    assign new_x      = new_reg[0];
    assign new_y      = new_reg[1];
    assign new_z      = new_reg[2];
    assign out_moment = out_ms_reg;
    assign out_last   = out_last_reg;

    // a frozen pipeline keeps every valid bit in place
    a_freeze_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !pipe_en |=> $stable(v_reg))
        else $error("valid bits moved while the pipeline was frozen");

    // a gain-affecting write starts the gain sequencer
    a_gain_restart: assert property (@(posedge clk) disable iff (!rst_n)
        gain_start |=> gstat.busy)
        else $error("gain unit idle after a gyro or damping write");

    // no spin enters while the gain is being recomputed
    a_no_entry_busy: assert property (@(posedge clk) disable iff (!rst_n)
        gstat.busy && pipe_en |=> !v_reg[1])
        else $error("spin accepted while the gain was not ready");

endmodule

/* rtl/core/llg_div_pipe.sv */
// pipelined signed-by-unsigned divider, one quotient bit per stage, saturating
module llg_div_pipe (
    input  logic                      clk,
    input  logic                      en,
    input  llg_pkg::prod_t            num,
    input  logic [llg_pkg::QUO_W-1:0] den,
    output llg_pkg::word_t            quo
);
    import llg_pkg::*;

    logic [PROD_W-1:0] mag_reg;
    logic              neg_a_reg;
    logic [QUO_W-1:0]  den_a_reg;

    logic [QUO_W-1:0]  rem_reg [QUO_W+1];
    logic [QUO_W-1:0]  lo_reg  [QUO_W+1];
    logic [QUO_W-1:0]  q_reg   [QUO_W+1];
    logic [QUO_W-1:0]  den_reg [QUO_W+1];
    logic              neg_reg [QUO_W+1];
    logic              ovf_reg [QUO_W+1];
    word_t             quo_reg;

    logic [QUO_W:0]    r2   [QUO_W];
    logic [QUO_W:0]    diff [QUO_W];
    logic              ge   [QUO_W];
    logic              ovf0;
    logic [QUO_W-1:0]  qf;
    logic [QUO_W-1:0]  nq;
    logic [QUO_W-1:0]  half;

    assign ovf0 = mag_reg[PROD_W-1:QUO_W] >= den_a_reg;
    assign half = {1'b1, {(QUO_W-1){1'b0}}};
    assign qf   = q_reg[QUO_W];
    assign nq   = ~qf + 1'b1;

    always_comb
    begin
        for (int k = 0; k < QUO_W; k++)
        begin
            r2[k]   = {rem_reg[k], lo_reg[k][QUO_W-1]};
            diff[k] = r2[k] - {1'b0, den_reg[k]};
            ge[k]   = r2[k] >= {1'b0, den_reg[k]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // magnitude and sign
            mag_reg   <= num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
            neg_a_reg <= num[PROD_W-1];
            den_a_reg <= den;
            // overflow check and remainder seed
            rem_reg[0] <= ovf0 ? '0 : mag_reg[PROD_W-1:QUO_W];
            lo_reg[0]  <= mag_reg[QUO_W-1:0];
            q_reg[0]   <= '0;
            den_reg[0] <= den_a_reg;
            neg_reg[0] <= neg_a_reg;
            ovf_reg[0] <= ovf0;
            for (int k = 0; k < QUO_W; k++)
            begin
                rem_reg[k+1] <= ge[k] ? diff[k][QUO_W-1:0] : r2[k][QUO_W-1:0];
                lo_reg[k+1]  <= lo_reg[k] << 1;
                q_reg[k+1]   <= {q_reg[k][QUO_W-2:0], ge[k]};
                den_reg[k+1] <= den_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                ovf_reg[k+1] <= ovf_reg[k];
            end
            // saturate toward the signed range
            if (neg_reg[QUO_W])
            begin
                if (ovf_reg[QUO_W] || qf > half)
                    quo_reg <= 32'sh80000000;
                else
                    quo_reg <= word_t'(nq);
            end
            else
            begin
                if (ovf_reg[QUO_W] || qf[QUO_W-1])
                    quo_reg <= 32'sh7fffffff;
                else
                    quo_reg <= word_t'(qf);
            end
        end
    end

    assign quo = quo_reg;

endmodule

/* rtl/core/llg_sqrt_pipe.sv */
// pipelined integer square root, one root bit per stage
module llg_sqrt_pipe (
    input  logic                       clk,
    input  logic                       en,
    input  logic [llg_pkg::PROD_W-1:0] val,
    output logic [llg_pkg::QUO_W-1:0]  root
);
    import llg_pkg::*;

    localparam int REM_W = QUO_W + 4;

    logic [PROD_W-1:0] n_reg    [SQRT_LAT];
    logic [REM_W-1:0]  rem_reg  [SQRT_LAT];
    logic [QUO_W-1:0]  root_reg [SQRT_LAT];

    logic [PROD_W-1:0] n_in    [SQRT_LAT];
    logic [REM_W-1:0]  rem_in  [SQRT_LAT];
    logic [QUO_W-1:0]  root_in [SQRT_LAT];
    logic [REM_W-1:0]  r4      [SQRT_LAT];
    logic [REM_W-1:0]  trial   [SQRT_LAT];
    logic              ge      [SQRT_LAT];

    always_comb
    begin
        for (int k = 0; k < SQRT_LAT; k++)
        begin
            if (k == 0)
            begin
                n_in[k]    = val;
                rem_in[k]  = '0;
                root_in[k] = '0;
            end
            else
            begin
                n_in[k]    = n_reg[k-1];
                rem_in[k]  = rem_reg[k-1];
                root_in[k] = root_reg[k-1];
            end
            r4[k]    = {rem_in[k][REM_W-3:0], n_in[k][PROD_W-1:PROD_W-2]};
            trial[k] = {2'b00, root_in[k], 2'b01};
            ge[k]    = r4[k] >= trial[k];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < SQRT_LAT; k++)
            begin
                n_reg[k]    <= n_in[k] << 2;
                rem_reg[k]  <= ge[k] ? (r4[k] - trial[k]) : r4[k];
                root_reg[k] <= {root_in[k][QUO_W-2:0], ge[k]};
            end
        end
    end

    assign root = root_reg[SQRT_LAT-1];

endmodule

/* rtl/core/llg_gain_calc.sv */
// sequential computation of gamma / (1 + alpha^2) after reset and on each start
module llg_gain_calc #(
    parameter int FRAC_BITS = llg_pkg::FRAC_BITS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  llg_pkg::mag_t       gamma,
    input  llg_pkg::mag_t       alpha,
    output llg_pkg::gain_stat_t stat
);
    import llg_pkg::*;

    localparam int CNT_W = $clog2(PROD_W);

    gain_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [PROD_W-1:0] sq_reg, den_reg, num_reg, quo_reg, rem_reg;
    logic              do_square, do_load, do_step, busy;
    logic [PROD_W:0]   r2, diff;
    logic              ge;

    assign r2   = {rem_reg, num_reg[PROD_W-1]};
    assign diff = r2 - {1'b0, den_reg};
    assign ge   = r2 >= {1'b0, den_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            GAIN_IDLE:   state_next = GAIN_IDLE;
            GAIN_SQUARE: state_next = GAIN_LOAD;
            GAIN_LOAD:   state_next = GAIN_DIVIDE;
            GAIN_DIVIDE:
            begin
                if (cnt_reg == CNT_W'(PROD_W - 1))
                    state_next = GAIN_IDLE;
            end
            default:     state_next = GAIN_IDLE;
        endcase
        if (start)
            state_next = GAIN_SQUARE;
    end

    always_comb
    begin
        do_square = 1'b0;
        do_load   = 1'b0;
        do_step   = 1'b0;
        busy      = 1'b1;
        case (state_reg)
            GAIN_IDLE:   busy = 1'b0;
            GAIN_SQUARE: do_square = 1'b1;
            GAIN_LOAD:   do_load = 1'b1;
            GAIN_DIVIDE: do_step = 1'b1;
            default:     busy = 1'b0;
        endcase
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_load)
            cnt_next = '0;
        else if (do_step)
            cnt_next = cnt_reg + 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= GAIN_SQUARE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_square)
            sq_reg <= PROD_W'(alpha) * PROD_W'(alpha);
        if (do_load)
        begin
            den_reg <= (PROD_W'(1) << FRAC_BITS) + (sq_reg >> FRAC_BITS);
            num_reg <= PROD_W'(gamma) << FRAC_BITS;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (do_step)
        begin
            rem_reg <= ge ? diff[PROD_W-1:0] : r2[PROD_W-1:0];
            num_reg <= num_reg << 1;
            quo_reg <= {quo_reg[PROD_W-2:0], ge};
        end
    end

    // quotient never exceeds gamma, so the low bits hold it
    always_comb
    begin
        stat.busy = busy;
        stat.gain = quo_reg[MAG_W-1:0];
    end

endmodule
